[src/radix_digit_emitter_macros.svh]
// Assertion macros used by the emitter's back module.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef RADIX_DIGIT_EMITTER_MACROS_SVH
`define RADIX_DIGIT_EMITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rde_pkg.sv]
package rde_pkg;

    // Digit storage and radix limits.
    localparam int MAX_DIGITS = 32;
    localparam int MAX_RADIX  = 16;

    // Field widths.
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int DIGIT_W     = $clog2(MAX_RADIX);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int VALUE_BYTES = VALUE_W / BYTE_W;
    localparam int BYTE_CNT_W  = $clog2(VALUE_BYTES);

    // Alphabet storage: two 64-bit words of eight characters each.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int ALPHA_W     = 2 * CFG_DATA_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Characters that an alphabet may not hold.
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA_LOW    = 2'd0,
        CFG_ALPHA_HIGH   = 2'd1,
        CFG_ALPHA_LENGTH = 2'd2
    } cfg_index_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               bad;
    } item_t;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

[src/rde_front.sv]
module rde_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [rde_pkg::VALUE_W-1:0]         value,
    input  logic [rde_pkg::ALPHA_W-1:0]         alphabet,
    input  logic [rde_pkg::LEN_W-1:0]           alpha_len,
    output rde_pkg::q_head_t                    head,
    input  logic                                head_pop
);

    logic                           alpha_ok;
    logic                           push_ok;
    logic                           pop_ok;
    rde_pkg::item_t                 q_mem [rde_pkg::QUEUE_DEPTH];
    logic [rde_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rde_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [rde_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rde_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [rde_pkg::QCNT_W-1:0]     count_reg;
    logic [rde_pkg::QCNT_W-1:0]     count_next;

    // Check the alphabet: length, forbidden characters and duplicates.
    always_comb
    begin
        logic [rde_pkg::CHAR_W-1:0] ci;
        alpha_ok = (alpha_len >= rde_pkg::LEN_W'(2))
                && (alpha_len <= rde_pkg::LEN_W'(rde_pkg::MAX_RADIX));
        for (int i = 0; i < rde_pkg::MAX_RADIX; i++)
        begin
            ci = alphabet[i*rde_pkg::CHAR_W +: rde_pkg::CHAR_W];
            if (rde_pkg::LEN_W'(i) < alpha_len)
            begin
                if (ci == rde_pkg::CHAR_PLUS || ci == rde_pkg::CHAR_MINUS
                    || ci < rde_pkg::CHAR_LOW || ci > rde_pkg::CHAR_HIGH)
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < rde_pkg::MAX_RADIX; j++)
                begin
                    if (rde_pkg::LEN_W'(j) < alpha_len
                        && alphabet[j*rde_pkg::CHAR_W +: rde_pkg::CHAR_W] == ci)
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Queue handshake.
    assign full    = (count_reg == rde_pkg::QCNT_W'(rde_pkg::QUEUE_DEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = head_pop && head.valid;

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == rde_pkg::QPTR_W'(rde_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == rde_pkg::QPTR_W'(rde_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries hold the value and its classification.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem[wr_ptr_reg].value <= value;
            q_mem[wr_ptr_reg].bad   <= !alpha_ok;
        end
    end

endmodule

[src/rde_back.sv]
`include "radix_digit_emitter_macros.svh"

module rde_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rde_pkg::q_head_t                head,
    output logic                            head_pop,
    input  logic [rde_pkg::LEN_W-1:0]       radix,
    input  logic [rde_pkg::ALPHA_W-1:0]     alphabet,
    output logic                            out_valid,
    input  logic                            out_pop,
    output logic [rde_pkg::CHAR_W-1:0]      out_char,
    output logic                            out_last,
    output logic                            out_bad
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [rde_pkg::VALUE_W-1:0]        work_reg;
    logic [rde_pkg::VALUE_W-1:0]        work_next;
    logic [rde_pkg::VALUE_W-1:0]        quot_reg;
    logic [rde_pkg::VALUE_W-1:0]        quot_next;
    logic [rde_pkg::DIGIT_W-1:0]        rem_reg;
    logic [rde_pkg::DIGIT_W-1:0]        rem_next;
    logic [rde_pkg::BYTE_CNT_W-1:0]     bcnt_reg;
    logic [rde_pkg::BYTE_CNT_W-1:0]     bcnt_next;
    logic [rde_pkg::CNT_W-1:0]          cnt_reg;
    logic [rde_pkg::CNT_W-1:0]          cnt_next;
    logic [rde_pkg::CNT_W-1:0]          left_reg;
    logic [rde_pkg::CNT_W-1:0]          left_next;
    logic                               rd_valid_reg;
    logic                               rd_valid_next;
    logic                               rd_last_reg;
    logic                               rd_last_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [rde_pkg::CHAR_W-1:0]         out_char_reg;
    logic [rde_pkg::CHAR_W-1:0]         out_char_next;
    logic                               out_last_reg;
    logic                               out_last_next;
    logic                               out_bad_reg;
    logic                               out_bad_next;

    logic [rde_pkg::DIGIT_W-1:0]        digit_mem [rde_pkg::MAX_DIGITS];
    logic [rde_pkg::DIGIT_W-1:0]        rdata_reg;
    logic [rde_pkg::CNT_W-1:0]          rd_addr;

    logic                               out_pop_ok;
    logic                               out_free;
    logic                               rd_to_out;
    logic                               rd_free;
    logic                               issue;
    logic                               bad_take;
    logic                               good_take;
    logic                               digit_done;
    logic                               wr_en;
    logic [rde_pkg::DIGIT_W+rde_pkg::BYTE_W-1:0] step;
    logic [rde_pkg::DIGIT_W-1:0]        rem_new;
    logic [rde_pkg::BYTE_W-1:0]         qbyte;
    logic [rde_pkg::VALUE_W-1:0]        quot_new;

    // Eight restoring division steps on one byte: returns remainder and quotient byte.
    function automatic logic [rde_pkg::DIGIT_W+rde_pkg::BYTE_W-1:0] div_byte(
        input logic [rde_pkg::DIGIT_W-1:0] rem_in,
        input logic [rde_pkg::BYTE_W-1:0]  byte_in,
        input logic [rde_pkg::LEN_W-1:0]   dvs
    );
        logic [rde_pkg::LEN_W-1:0]  r;
        logic [rde_pkg::BYTE_W-1:0] q;
        r = rde_pkg::LEN_W'(rem_in);
        q = '0;
        for (int b = rde_pkg::BYTE_W - 1; b >= 0; b--)
        begin
            r = {r[rde_pkg::LEN_W-2:0], byte_in[b]};
            if (r >= dvs)
            begin
                r    = r - dvs;
                q[b] = 1'b1;
            end
        end
        return {r[rde_pkg::DIGIT_W-1:0], q};
    endfunction

    // Index of the highest nonzero byte; zero for a zero value.
    function automatic logic [rde_pkg::BYTE_CNT_W-1:0] top_byte(
        input logic [rde_pkg::VALUE_W-1:0] v
    );
        logic [rde_pkg::BYTE_CNT_W-1:0] t;
        t = '0;
        for (int b = 1; b < rde_pkg::VALUE_BYTES; b++)
        begin
            if (v[b*rde_pkg::BYTE_W +: rde_pkg::BYTE_W] != '0)
            begin
                t = rde_pkg::BYTE_CNT_W'(b);
            end
        end
        return t;
    endfunction

    // Move the highest nonzero byte to the top of the word.
    function automatic logic [rde_pkg::VALUE_W-1:0] align_top(
        input logic [rde_pkg::VALUE_W-1:0]    v,
        input logic [rde_pkg::BYTE_CNT_W-1:0] t
    );
        return v << (rde_pkg::BYTE_W * (rde_pkg::VALUE_BYTES - 1 - int'(t)));
    endfunction

    // Handshake between the read stage, the output register and the queue.
    assign out_pop_ok = out_pop && out_valid_reg;
    assign out_free   = !out_valid_reg || out_pop_ok;
    assign rd_to_out  = rd_valid_reg && out_free;
    assign rd_free    = !rd_valid_reg || rd_to_out;
    assign issue      = (state_reg == ST_EMIT) && rd_free;
    assign bad_take   = (state_reg == ST_IDLE) && head.valid && head.item.bad
                     && !rd_valid_reg && out_free;
    assign good_take  = (state_reg == ST_IDLE) && head.valid && !head.item.bad;
    assign head_pop   = bad_take || good_take;

    // One byte of the running division per cycle.
    assign step       = div_byte(rem_reg, work_reg[rde_pkg::VALUE_W-1 -: rde_pkg::BYTE_W],
                                 radix);
    assign rem_new    = step[rde_pkg::DIGIT_W+rde_pkg::BYTE_W-1 -: rde_pkg::DIGIT_W];
    assign qbyte      = step[rde_pkg::BYTE_W-1:0];
    assign quot_new   = {quot_reg[rde_pkg::VALUE_W-rde_pkg::BYTE_W-1:0], qbyte};
    assign digit_done = (state_reg == ST_DIV) && (bcnt_reg == '0);
    assign wr_en      = digit_done && (cnt_reg < rde_pkg::CNT_W'(rde_pkg::MAX_DIGITS));

    // Digits are read back from the most significant one down.
    assign rd_addr    = left_reg - 1'b1;

    // Next-state logic.
    always_comb
    begin
        logic [rde_pkg::BYTE_CNT_W-1:0] t;
        logic [rde_pkg::CNT_W-1:0]      cnt_inc;
        state_next     = state_reg;
        work_next      = work_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        bcnt_next      = bcnt_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        rd_valid_next  = rd_valid_reg;
        rd_last_next   = rd_last_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        t              = '0;
        cnt_inc        = wr_en ? cnt_reg + 1'b1 : cnt_reg;

        // Output register drains, then refills from the read stage or a rejection.
        if (out_pop_ok)
        begin
            out_valid_next = 1'b0;
        end
        if (rd_to_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = alphabet[rdata_reg*rde_pkg::CHAR_W +: rde_pkg::CHAR_W];
            out_last_next  = rd_last_reg;
            out_bad_next   = 1'b0;
            rd_valid_next  = 1'b0;
        end
        if (bad_take)
        begin
            out_valid_next = 1'b1;
            out_char_next  = '0;
            out_last_next  = 1'b1;
            out_bad_next   = 1'b1;
        end

        // Memory read issue during emission.
        if (issue)
        begin
            rd_valid_next = 1'b1;
            rd_last_next  = (left_reg == rde_pkg::CNT_W'(1));
            left_next     = left_reg - 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (good_take)
                begin
                    t          = top_byte(head.item.value);
                    work_next  = align_top(head.item.value, t);
                    bcnt_next  = t;
                    quot_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                work_next = work_reg << rde_pkg::BYTE_W;
                quot_next = quot_new;
                rem_next  = rem_new;
                bcnt_next = bcnt_reg - 1'b1;
                if (digit_done)
                begin
                    cnt_next = cnt_inc;
                    if (quot_new == '0)
                    begin
                        left_next  = cnt_inc;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        t         = top_byte(quot_new);
                        work_next = align_top(quot_new, t);
                        bcnt_next = t;
                        quot_next = '0;
                        rem_next  = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue && left_reg == rde_pkg::CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            work_reg      <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            bcnt_reg      <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            bcnt_reg      <= bcnt_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    // Digit store: written once per finished digit, read with registered data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[cnt_reg[rde_pkg::IDX_W-1:0]] <= rem_new;
        end
        if (issue)
        begin
            rdata_reg <= digit_mem[rd_addr[rde_pkg::IDX_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

    // Emission only runs with digits pending, and never past what was stored.
    `RDE_ASSERT_SAME(a_emit_in_range, state_reg == ST_EMIT, left_reg != '0 && left_reg <= cnt_reg, "emission index out of range")
    // A rejection result always closes its transaction and carries no character.
    `RDE_ASSERT_SAME(a_bad_is_last, out_valid_reg && out_bad_reg, out_last_reg && out_char_reg == '0, "rejection result malformed")
    // A rejection is taken only once the read stage is empty, so it cannot overtake a digit.
    `RDE_ASSERT_NEXT(a_bad_in_order, bad_take, !rd_valid_reg && out_valid_reg && out_bad_reg, "rejection overtook a digit")
    // The digit count never exceeds the store depth.
    `RDE_ASSERT_SAME(a_count_bound, 1'b1, cnt_reg <= rde_pkg::CNT_W'(rde_pkg::MAX_DIGITS), "digit count overflow")

endmodule

[src/radix_digit_emitter.sv]
// Channel      Direction  Handshake              Payload
// input        in         push / full            value
// result       out        pop / empty            digit_char, last, bad_alphabet
// config       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For each digit the divider works through the significant bytes of the running quotient
// (one to four); the digits are emitted once all of them are stored, as pop allows.
// A rejected alphabet yields its single result once the read stage and output register are free.
// Reset clears all control state; the digit store holds no reset value.
// A two-entry queue accepts new values while the back divides or waits on pop.
// Configuration is always ready and must only be written while the block is idle.
module radix_digit_emitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [rde_pkg::VALUE_W-1:0]         value,
    output logic                                empty,
    input  logic                                pop,
    output logic [rde_pkg::CHAR_W-1:0]          digit_char,
    output logic                                last,
    output logic                                bad_alphabet,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rde_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rde_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [rde_pkg::CFG_DATA_W-1:0]  alpha_low_reg;
    logic [rde_pkg::CFG_DATA_W-1:0]  alpha_high_reg;
    logic [rde_pkg::LEN_W-1:0]       alpha_len_reg;
    logic [rde_pkg::ALPHA_W-1:0]     alphabet;
    rde_pkg::q_head_t                head;
    logic                            head_pop;
    logic                            out_valid;

    // Configuration registers; writes to unused indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rde_pkg::CFG_ALPHA_LOW:
                begin
                    alpha_low_reg <= cfg_data;
                end
                rde_pkg::CFG_ALPHA_HIGH:
                begin
                    alpha_high_reg <= cfg_data;
                end
                rde_pkg::CFG_ALPHA_LENGTH:
                begin
                    alpha_len_reg <= cfg_data[rde_pkg::LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign alphabet = {alpha_high_reg, alpha_low_reg};

    // Front: takes each transaction, checks the alphabet and queues the result.
    rde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .alphabet  (alphabet),
        .alpha_len (alpha_len_reg),
        .head      (head),
        .head_pop  (head_pop)
    );

    // Back: divides, stores digits and emits them most significant first.
    rde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_pop  (head_pop),
        .radix     (alpha_len_reg),
        .alphabet  (alphabet),
        .out_valid (out_valid),
        .out_pop   (pop),
        .out_char  (digit_char),
        .out_last  (last),
        .out_bad   (bad_alphabet)
    );

    assign empty = !out_valid;

endmodule
